@@ rtl/cpualu_pkg.sv @@
// shared types and constants for the cpu alu with flags
// opcode codes, flag bit positions and the request / result structs
// no dependencies
`default_nettype none

package cpualu_pkg;

   // opcode codes
   localparam logic [4:0] OP_ADD   = 5'd0;
   localparam logic [4:0] OP_ADC   = 5'd1;
   localparam logic [4:0] OP_SUB   = 5'd2;
   localparam logic [4:0] OP_SBC   = 5'd3;
   localparam logic [4:0] OP_AND   = 5'd4;
   localparam logic [4:0] OP_XOR   = 5'd5;
   localparam logic [4:0] OP_OR    = 5'd6;
   localparam logic [4:0] OP_CP    = 5'd7;
   localparam logic [4:0] OP_INC8  = 5'd8;
   localparam logic [4:0] OP_DEC8  = 5'd9;
   localparam logic [4:0] OP_ADD16 = 5'd10;
   localparam logic [4:0] OP_ADDSP = 5'd11;
   localparam logic [4:0] OP_INC16 = 5'd12;
   localparam logic [4:0] OP_DEC16 = 5'd13;
   localparam logic [4:0] OP_BIT   = 5'd14;
   localparam logic [4:0] OP_RES   = 5'd15;
   localparam logic [4:0] OP_SET   = 5'd16;

   // flag bit positions within the flag nibble
   localparam int FLAG_Z_BIT = 3;
   localparam int FLAG_N_BIT = 2;
   localparam int FLAG_H_BIT = 1;
   localparam int FLAG_C_BIT = 0;

   // one captured request
   typedef struct packed {
      logic [4:0]  opcode;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [2:0]  bit_index;
      logic [3:0]  flags_in;
   } alu_req_type;

   // one computed result
   typedef struct packed {
      logic [15:0] result;
      logic        write_back;
      logic        zero_flag;
      logic        subtract_flag;
      logic        half_carry_flag;
      logic        carry_flag;
   } alu_rsp_type;

endpackage

`default_nettype wire

@@ rtl/cpu_alu_with_flags.sv @@
// A request passes the request register, then the result register, before its strobe.
// Throughput: one request every cycle; the request register and the result
// register around the alu datapath set this, and busy never rises.
// Results cannot be stalled by the receiver: each shows for exactly one cycle.
// Reset (synchronous, active high) clears the request and result strobes only.
// Depends on cpualu_pkg and cpualu_core.
`default_nettype none

module cpu_alu_with_flags
   import cpualu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [4:0]  req_opcode,
   input  wire logic [15:0] req_operand_a,
   input  wire logic [15:0] req_operand_b,
   input  wire logic [2:0]  req_bit_index,
   input  wire logic [3:0]  req_flags_in,
   output      logic        rsp_strobe,
   output      logic [15:0] rsp_result,
   output      logic        rsp_write_back,
   output      logic        rsp_zero_flag,
   output      logic        rsp_subtract_flag,
   output      logic        rsp_half_carry_flag,
   output      logic        rsp_carry_flag
);

   alu_req_type req_ff;
   alu_req_type req_in;
   logic        req_valid_ff;
   logic        req_valid_in;
   alu_rsp_type rsp_ff;
   alu_rsp_type rsp_in;
   logic        rsp_strobe_ff;
   logic        rsp_strobe_in;
   logic        take;

   // one request per cycle, never held off
   assign busy = 1'b0;
   assign take = start & ~busy;

   // request register
   assign req_valid_in     = take;
   assign req_in.opcode    = req_opcode;
   assign req_in.operand_a = req_operand_a;
   assign req_in.operand_b = req_operand_b;
   assign req_in.bit_index = req_bit_index;
   assign req_in.flags_in  = req_flags_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_in;
      end
   end

   // alu datapath
   cpualu_core u_core (
      .req (req_ff),
      .rsp (rsp_in)
   );

   // result register
   assign rsp_strobe_in = req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_result          = rsp_ff.result;
   assign rsp_write_back      = rsp_ff.write_back;
   assign rsp_zero_flag       = rsp_ff.zero_flag;
   assign rsp_subtract_flag   = rsp_ff.subtract_flag;
   assign rsp_half_carry_flag = rsp_ff.half_carry_flag;
   assign rsp_carry_flag      = rsp_ff.carry_flag;

endmodule

`default_nettype wire

@@ rtl/cpualu_core.sv @@
// alu datapath: one request in, one result out, purely combinational
// covers 8-bit and 16-bit arithmetic, logic and single-bit operations
// depends on cpualu_pkg
`default_nettype none

module cpualu_core
   import cpualu_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [7:0]  a8;
   logic [7:0]  b8;
   logic        cin;
   logic        add_k;
   logic        sub_k;
   logic [8:0]  add_sum;
   logic [4:0]  add_half;
   logic [8:0]  sub_diff;
   logic [4:0]  sub_half;
   logic [7:0]  inc8;
   logic [7:0]  dec8;
   logic [16:0] wide_sum;
   logic [12:0] wide_half;
   logic [15:0] offs;
   logic [15:0] sp_sum;
   logic [4:0]  sp_half;
   logic [8:0]  sp_carry;
   logic [7:0]  bit_mask;
   logic [15:0] res;
   logic        wb;
   logic        fz;
   logic        fn;
   logic        fh;
   logic        fc;

   assign a8  = req.operand_a[7:0];
   assign b8  = req.operand_b[7:0];
   assign cin = req.flags_in[FLAG_C_BIT];

   // 8-bit add with optional carry in
   assign add_k    = (req.opcode == OP_ADC) ? cin : 1'b0;
   assign add_sum  = {1'b0, a8} + {1'b0, b8} + {8'd0, add_k};
   assign add_half = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, add_k};

   // 8-bit subtract with optional borrow; the top bit is the borrow out
   assign sub_k    = (req.opcode == OP_SBC) ? cin : 1'b0;
   assign sub_diff = {1'b0, a8} - {1'b0, b8} - {8'd0, sub_k};
   assign sub_half = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, sub_k};

   // 8-bit increment and decrement
   assign inc8 = a8 + 8'd1;
   assign dec8 = a8 - 8'd1;

   // 16-bit add, half carry out of bit 11
   assign wide_sum  = {1'b0, req.operand_a} + {1'b0, req.operand_b};
   assign wide_half = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};

   // 16-bit add of a signed byte, flags from the unsigned low-byte add
   assign offs     = {{8{b8[7]}}, b8};
   assign sp_sum   = req.operand_a + offs;
   assign sp_half  = {1'b0, req.operand_a[3:0]} + {1'b0, b8[3:0]};
   assign sp_carry = {1'b0, req.operand_a[7:0]} + {1'b0, b8};

   // single-bit mask
   assign bit_mask = 8'd1 << req.bit_index;

   // operation select
   always_comb begin
      res = 16'd0;
      wb  = 1'b1;
      fz  = req.flags_in[FLAG_Z_BIT];
      fn  = req.flags_in[FLAG_N_BIT];
      fh  = req.flags_in[FLAG_H_BIT];
      fc  = req.flags_in[FLAG_C_BIT];
      unique case (req.opcode)
         OP_ADD, OP_ADC: begin
            res = {8'd0, add_sum[7:0]};
            fz  = (add_sum[7:0] == 8'd0);
            fn  = 1'b0;
            fh  = add_half[4];
            fc  = add_sum[8];
         end
         OP_SUB, OP_SBC: begin
            res = {8'd0, sub_diff[7:0]};
            fz  = (sub_diff[7:0] == 8'd0);
            fn  = 1'b1;
            fh  = sub_half[4];
            fc  = sub_diff[8];
         end
         OP_CP: begin
            wb = 1'b0;
            fz = (sub_diff[7:0] == 8'd0);
            fn = 1'b1;
            fh = sub_half[4];
            fc = sub_diff[8];
         end
         OP_AND: begin
            res = {8'd0, a8 & b8};
            fz  = ((a8 & b8) == 8'd0);
            fn  = 1'b0;
            fh  = 1'b1;
            fc  = 1'b0;
         end
         OP_XOR: begin
            res = {8'd0, a8 ^ b8};
            fz  = ((a8 ^ b8) == 8'd0);
            fn  = 1'b0;
            fh  = 1'b0;
            fc  = 1'b0;
         end
         OP_OR: begin
            res = {8'd0, a8 | b8};
            fz  = ((a8 | b8) == 8'd0);
            fn  = 1'b0;
            fh  = 1'b0;
            fc  = 1'b0;
         end
         OP_INC8: begin
            res = {8'd0, inc8};
            fz  = (inc8 == 8'd0);
            fn  = 1'b0;
            fh  = (a8[3:0] == 4'hF);
         end
         OP_DEC8: begin
            res = {8'd0, dec8};
            fz  = (dec8 == 8'd0);
            fn  = 1'b1;
            fh  = (a8[3:0] == 4'h0);
         end
         OP_ADD16: begin
            res = wide_sum[15:0];
            fn  = 1'b0;
            fh  = wide_half[12];
            fc  = wide_sum[16];
         end
         OP_ADDSP: begin
            res = sp_sum;
            fz  = 1'b0;
            fn  = 1'b0;
            fh  = sp_half[4];
            fc  = sp_carry[8];
         end
         OP_INC16: res = req.operand_a + 16'd1;
         OP_DEC16: res = req.operand_a - 16'd1;
         OP_BIT: begin
            wb = 1'b0;
            fz = ((a8 & bit_mask) == 8'd0);
            fn = 1'b0;
            fh = 1'b1;
         end
         OP_RES: res = {8'd0, a8 & ~bit_mask};
         OP_SET: res = {8'd0, a8 | bit_mask};
         default: wb = 1'b0;
      endcase
   end

   assign rsp.result          = res;
   assign rsp.write_back      = wb;
   assign rsp.zero_flag       = fz;
   assign rsp.subtract_flag   = fn;
   assign rsp.half_carry_flag = fh;
   assign rsp.carry_flag      = fc;

endmodule

`default_nettype wire

@@ rtl/cpualu_chk.sv @@
// port-level checks for the cpu alu with flags, attached by bind
// depends on cpualu_pkg and the top level cpu_alu_with_flags
`default_nettype none

module cpualu_chk
   import cpualu_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [4:0]  req_opcode,
   input wire logic [3:0]  req_flags_in,
   input wire logic        rsp_strobe,
   input wire logic [15:0] rsp_result,
   input wire logic        rsp_write_back,
   input wire logic        rsp_zero_flag,
   input wire logic        rsp_subtract_flag,
   input wire logic        rsp_half_carry_flag,
   input wire logic        rsp_carry_flag
);

   logic took;

   assign took = start & ~busy;

   // every request gives a result strobe through the request and result registers
   a_req_to_rsp : assert property (@(posedge clock) disable iff (reset)
      took |=> ##1 rsp_strobe)
      else $error("request without result strobe");

   // no result strobe without a matching earlier request
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(took, 2))
      else $error("result strobe without request");

   // compare and bit test write nothing back
   a_no_writeback : assert property (@(posedge clock) disable iff (reset)
      (took && (req_opcode == OP_CP || req_opcode == OP_BIT))
      |=> ##1 (!rsp_write_back && rsp_result == 16'd0))
      else $error("compare or bit test wrote back");

   // 16-bit increment and decrement leave every flag alone
   a_inc16_flags : assert property (@(posedge clock) disable iff (reset)
      (took && (req_opcode == OP_INC16 || req_opcode == OP_DEC16))
      |=> ##1 ({rsp_zero_flag, rsp_subtract_flag, rsp_half_carry_flag, rsp_carry_flag}
               == $past(req_flags_in, 2)))
      else $error("16-bit step changed flags");

endmodule

bind cpu_alu_with_flags cpualu_chk u_cpualu_chk (.*);

`default_nettype wire

@@ bench/tb_cpu_alu_with_flags.sv @@
// self-checking bench for cpu_alu_with_flags: directed corner requests, then random ones
// a scoreboard class predicts every result from the accepted request and checks it
// depends on cpualu_pkg and the cpu_alu_with_flags rtl
`timescale 1ns / 1ps

module tb_cpu_alu_with_flags
   import cpualu_pkg::*;
();

   localparam int RANDOM_REQUESTS = 1350;
   localparam int CYCLE_LIMIT     = 60000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int IDLE_PERCENT    = 13;
   localparam int CALM_FIRST      = 400;
   localparam int CALM_LAST       = 700;

   // expected alu results, predicted from each accepted request
   class alu_flag_scoreboard;
      alu_rsp_type pending_results[$];
      int unsigned error_count;

      function new();
         error_count = 0;
      endfunction

      // independent model of the alu datapath and its flag rules
      function alu_rsp_type predict_alu_result(alu_req_type rq);
         alu_rsp_type rs;
         logic [7:0]  a;
         logic [7:0]  b;
         logic [7:0]  r8;
         logic [8:0]  s9;
         logic [16:0] s17;
         logic [15:0] ext;
         logic [15:0] res;
         logic        wb;
         logic        k;
         logic        z;
         logic        n;
         logic        h;
         logic        c;
         a   = rq.operand_a[7:0];
         b   = rq.operand_b[7:0];
         z   = rq.flags_in[FLAG_Z_BIT];
         n   = rq.flags_in[FLAG_N_BIT];
         h   = rq.flags_in[FLAG_H_BIT];
         c   = rq.flags_in[FLAG_C_BIT];
         res = 16'h0000;
         wb  = 1'b1;
         k   = 1'b0;
         case (rq.opcode)
            OP_ADD, OP_ADC: begin
               k   = (rq.opcode == OP_ADC) ? c : 1'b0;
               s9  = {1'b0, a} + {1'b0, b} + {8'h00, k};
               res = {8'h00, s9[7:0]};
               z   = (s9[7:0] == 8'h00);
               n   = 1'b0;
               h   = ({1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, k}) > 5'h0F;
               c   = s9[8];
            end
            OP_SUB, OP_SBC, OP_CP: begin
               k   = (rq.opcode == OP_SBC) ? c : 1'b0;
               r8  = a - b - {7'h00, k};
               res = {8'h00, r8};
               z   = (r8 == 8'h00);
               n   = 1'b1;
               h   = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'h0, k});
               c   = {1'b0, a} < ({1'b0, b} + {8'h00, k});
               if (rq.opcode == OP_CP) begin
                  wb  = 1'b0;
                  res = 16'h0000;
               end
            end
            OP_AND: begin
               res = {8'h00, a & b};
               z = (res == 16'h0000); n = 1'b0; h = 1'b1; c = 1'b0;
            end
            OP_XOR: begin
               res = {8'h00, a ^ b};
               z = (res == 16'h0000); n = 1'b0; h = 1'b0; c = 1'b0;
            end
            OP_OR: begin
               res = {8'h00, a | b};
               z = (res == 16'h0000); n = 1'b0; h = 1'b0; c = 1'b0;
            end
            OP_INC8: begin
               r8  = a + 8'h01;
               res = {8'h00, r8};
               z = (r8 == 8'h00); n = 1'b0; h = (a[3:0] == 4'hF);
            end
            OP_DEC8: begin
               r8  = a - 8'h01;
               res = {8'h00, r8};
               z = (r8 == 8'h00); n = 1'b1; h = (a[3:0] == 4'h0);
            end
            OP_ADD16: begin
               s17 = {1'b0, rq.operand_a} + {1'b0, rq.operand_b};
               res = s17[15:0];
               n   = 1'b0;
               h   = ({1'b0, rq.operand_a[11:0]} + {1'b0, rq.operand_b[11:0]}) > 13'h0FFF;
               c   = s17[16];
            end
            OP_ADDSP: begin
               ext = {{8{b[7]}}, b};
               res = rq.operand_a + ext;
               z = 1'b0; n = 1'b0;
               h = ({1'b0, rq.operand_a[3:0]} + {1'b0, b[3:0]}) > 5'h0F;
               c = ({1'b0, rq.operand_a[7:0]} + {1'b0, b}) > 9'h0FF;
            end
            OP_INC16: res = rq.operand_a + 16'h0001;
            OP_DEC16: res = rq.operand_a - 16'h0001;
            OP_BIT: begin
               z = ~a[rq.bit_index]; n = 1'b0; h = 1'b1;
               wb = 1'b0; res = 16'h0000;
            end
            OP_RES: res = {8'h00, a & ~(8'h01 << rq.bit_index)};
            OP_SET: res = {8'h00, a | (8'h01 << rq.bit_index)};
            default: begin
               res = 16'h0000;
               wb  = 1'b0;
            end
         endcase
         rs.result          = res;
         rs.write_back      = wb;
         rs.zero_flag       = z;
         rs.subtract_flag   = n;
         rs.half_carry_flag = h;
         rs.carry_flag      = c;
         return rs;
      endfunction

      function void record_request(alu_req_type rq);
         pending_results.push_back(predict_alu_result(rq));
      endfunction

      function void compare_field(string fname, logic [15:0] exp_val, logic [15:0] act_val);
         if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_val,
                     act_val);
            error_count++;
         end
      endfunction

      function void check_result(alu_rsp_type got);
         alu_rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result with no pending request, actual %h", $time, got);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("result", want.result, got.result);
            compare_field("write_back", 16'(want.write_back), 16'(got.write_back));
            compare_field("zero_flag", 16'(want.zero_flag), 16'(got.zero_flag));
            compare_field("subtract_flag", 16'(want.subtract_flag),
                          16'(got.subtract_flag));
            compare_field("half_carry_flag", 16'(want.half_carry_flag),
                          16'(got.half_carry_flag));
            compare_field("carry_flag", 16'(want.carry_flag), 16'(got.carry_flag));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [4:0]  req_opcode;
   logic [15:0] req_operand_a;
   logic [15:0] req_operand_b;
   logic [2:0]  req_bit_index;
   logic [3:0]  req_flags_in;
   logic        rsp_strobe;
   logic [15:0] rsp_result;
   logic        rsp_write_back;
   logic        rsp_zero_flag;
   logic        rsp_subtract_flag;
   logic        rsp_half_carry_flag;
   logic        rsp_carry_flag;

   alu_flag_scoreboard board = new();
   int unsigned        cycle_count = 0;

   cpu_alu_with_flags i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_operand_a       (req_operand_a),
      .req_operand_b       (req_operand_b),
      .req_bit_index       (req_bit_index),
      .req_flags_in        (req_flags_in),
      .rsp_strobe          (rsp_strobe),
      .rsp_result          (rsp_result),
      .rsp_write_back      (rsp_write_back),
      .rsp_zero_flag       (rsp_zero_flag),
      .rsp_subtract_flag   (rsp_subtract_flag),
      .rsp_half_carry_flag (rsp_half_carry_flag),
      .rsp_carry_flag      (rsp_carry_flag)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // observe accepted requests and strobed results at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1)
            board.check_result({rsp_result, rsp_write_back, rsp_zero_flag, rsp_subtract_flag,
                                rsp_half_carry_flag, rsp_carry_flag});
         if (start && !busy)
            board.record_request({req_opcode, req_operand_a, req_operand_b, req_bit_index,
                                  req_flags_in});
      end
   end

   // present one request and hold it until the block takes it
   task automatic drive_request(logic [4:0] op, logic [15:0] a, logic [15:0] b,
                                logic [2:0] idx, logic [3:0] fl);
      req_opcode    <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      req_bit_index <= idx;
      req_flags_in  <= fl;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // drop start for a few cycles, with junk on the request lines
   task automatic pause_requests(int cycles);
      start         <= 1'b0;
      req_opcode    <= 5'($urandom);
      req_operand_a <= 16'($urandom);
      req_operand_b <= 16'($urandom);
      req_bit_index <= 3'($urandom);
      req_flags_in  <= 4'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // operands lean towards carry and sign boundaries
   function automatic logic [15:0] pick_operand();
      logic [15:0] corners [10] = '{16'h0000, 16'h00FF, 16'h000F, 16'h0010, 16'h0080,
                                     16'h007F, 16'hFFFF, 16'h0FFF, 16'hFF00, 16'hFF80};
      if ($urandom_range(0, 99) < 25)
         return corners[$urandom_range(0, 9)];
      return 16'($urandom);
   endfunction

   task automatic drive_random_request();
      logic [4:0] op;
      if ($urandom_range(0, 99) < 8)
         op = 5'($urandom_range(17, 31));
      else
         op = 5'($urandom_range(0, 16));
      drive_request(op, pick_operand(), pick_operand(), 3'($urandom_range(0, 7)),
                    4'($urandom_range(0, 15)));
   endtask

   initial begin
      reset         <= 1'b1;
      start         <= 1'b0;
      req_opcode    <= '0;
      req_operand_a <= '0;
      req_operand_b <= '0;
      req_bit_index <= '0;
      req_flags_in  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed corners: carries, borrows, zero results, sign offsets, bit ops
      drive_request(OP_ADD,   16'h00FF, 16'h0001, 3'd0, 4'h0);
      drive_request(OP_ADD,   16'hFF00, 16'hFF00, 3'd7, 4'hF);
      drive_request(OP_ADC,   16'h00FF, 16'h0000, 3'd0, 4'h1);
      drive_request(OP_ADC,   16'h000F, 16'h0000, 3'd0, 4'hE);
      drive_request(OP_SUB,   16'h0000, 16'h0001, 3'd0, 4'h0);
      drive_request(OP_SUB,   16'h00FF, 16'h00FF, 3'd0, 4'hF);
      drive_request(OP_SBC,   16'h0010, 16'h000F, 3'd0, 4'h1);
      drive_request(OP_SBC,   16'h0000, 16'h00FF, 3'd0, 4'h1);
      drive_request(OP_AND,   16'h00F0, 16'h000F, 3'd0, 4'h5);
      drive_request(OP_XOR,   16'hFFFF, 16'hFFFF, 3'd0, 4'hF);
      drive_request(OP_OR,    16'h0000, 16'h0000, 3'd0, 4'hA);
      drive_request(OP_CP,    16'h0042, 16'h0042, 3'd0, 4'h0);
      drive_request(OP_INC8,  16'h00FF, 16'h0000, 3'd0, 4'h1);
      drive_request(OP_DEC8,  16'h0000, 16'h0000, 3'd0, 4'h0);
      drive_request(OP_DEC8,  16'h0010, 16'h0000, 3'd0, 4'hF);
      drive_request(OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'h8);
      drive_request(OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'h0);
      drive_request(OP_ADDSP, 16'h0000, 16'h0080, 3'd0, 4'hF);
      drive_request(OP_ADDSP, 16'hFFFF, 16'h007F, 3'd0, 4'h0);
      drive_request(OP_INC16, 16'hFFFF, 16'h0000, 3'd0, 4'h6);
      drive_request(OP_DEC16, 16'h0000, 16'h0000, 3'd0, 4'h9);
      drive_request(OP_BIT,   16'h0080, 16'h0000, 3'd7, 4'h0);
      drive_request(OP_BIT,   16'hFF7F, 16'h0000, 3'd7, 4'h1);
      drive_request(OP_RES,   16'hFFFF, 16'h0000, 3'd7, 4'hF);
      drive_request(OP_SET,   16'h0000, 16'h0000, 3'd0, 4'h0);
      drive_request(5'd17,    16'hFFFF, 16'hFFFF, 3'd7, 4'hF);
      drive_request(5'd31,    16'h1234, 16'h5678, 3'd3, 4'h3);
      pause_requests(2);

      // random requests, with a calm stretch where start never drops
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         drive_random_request();
         if ((i < CALM_FIRST || i > CALM_LAST) && $urandom_range(0, 99) < IDLE_PERCENT)
            pause_requests($urandom_range(1, 3));
      end
      start <= 1'b0;

      // drain outstanding results
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.error_count == 0 && board.pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ cpu_alu_with_flags.f @@
rtl/cpualu_pkg.sv
rtl/cpualu_core.sv
rtl/cpu_alu_with_flags.sv
rtl/cpualu_chk.sv
bench/tb_cpu_alu_with_flags.sv
